/* rtl/core/rhss_pkg.sv */
// Shared constants, state encoding and result bundle of the rolling hash search.
`timescale 1ns / 1ps
`default_nettype none

package rhss_pkg;

  // Polynomial hash: base and modulus.
  localparam int HashBase = 17;
  localparam int HashMod  = 1009;
  localparam int HashW    = 10;

  // Operand width of the modulo unit; covers 255 * 1008 and 1008 * 17 + 255.
  localparam int ModXW    = 18;

  // Payload widths.
  localparam int ChW      = 8;
  localparam int PosW     = 16;
  localparam int PosMax   = 65535;

  // Parameter defaults.
  localparam int DefMaxPattern = 64;
  localparam int DefMaxText    = 65535;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PH_Q,
    ST_PH_R,
    ST_PP_Q,
    ST_PP_R,
    ST_OLD_RD,
    ST_DROP_Q,
    ST_DROP_R,
    ST_ROLL_Q,
    ST_ROLL_R,
    ST_V_RD,
    ST_V_CMP,
    ST_OUT
  } rhss_state_t;

  // Result beat handed from the sequencer to the output register.
  typedef struct packed {
    logic            load;
    logic            found;
    logic [PosW-1:0] position;
    logic            done_res;
    logic            pattern_error;
  } rhss_res_t;

endpackage

`default_nettype wire

/* rtl/core/rhss_if.sv */
// Valid/ready channel interfaces for request bytes and search results.
`timescale 1ns / 1ps
`default_nettype none

interface rhss_req_if import rhss_pkg::*; ();
  logic           valid;
  logic           ready;
  logic           req_type;
  logic [ChW-1:0] ch;
  logic           last;

  modport source (output valid, req_type, ch, last, input ready);
  modport sink (input valid, req_type, ch, last, output ready);
endinterface

interface rhss_res_if import rhss_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            found;
  logic [PosW-1:0] position;
  logic            done_res;
  logic            pattern_error;

  modport source (output valid, found, position, done_res, pattern_error, input ready);
  modport sink (input valid, found, position, done_res, pattern_error, output ready);
endinterface

`default_nettype wire

/* rtl/core/rhss_ram.sv */
// Simple dual-port synchronous RAM with one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rhss_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/rhss_mod.sv */
// Reduction modulo 1009 by reciprocal multiplication, with the quotient registered.
`timescale 1ns / 1ps
`default_nettype none

module rhss_mod import rhss_pkg::*; (
  input  wire logic             clk,
  input  wire logic [ModXW-1:0] x,
  output logic      [HashW-1:0] r
);

  // 2^28 / 1009 rounded up; exact quotient for every 18-bit operand.
  localparam int RecipShift = 28;
  localparam int RecipW     = 19;
  localparam int ProdW      = ModXW + RecipW;
  localparam int QW         = 9;
  localparam logic [RecipW-1:0] Recip = RecipW'(((64'd1 << RecipShift) + HashMod - 1) / HashMod);

  logic [ProdW-1:0] prod;
  logic [QW-1:0]    quot;
  logic [ModXW-1:0] diff;

  // First step: quotient estimate, registered before the back multiply.
  assign prod = ProdW'(x) * ProdW'(Recip);

  always_ff @(posedge clk) begin
    quot <= prod[RecipShift +: QW];
  end

  // Second step: remainder with a final correction step.
  assign diff = x - ModXW'(quot) * ModXW'(HashMod);

  always_comb begin
    if (diff >= ModXW'(HashMod)) begin
      r = HashW'(diff - ModXW'(HashMod));
    end else begin
      r = HashW'(diff);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rhss_ctrl.sv */
// Sequencer and hash datapath: pattern intake, window roll and match verification.
`timescale 1ns / 1ps
`default_nettype none

module rhss_ctrl import rhss_pkg::*; #(
  parameter int MAX_PATTERN = DefMaxPattern,
  parameter int MAX_TEXT    = DefMaxText,
  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // Request side.
  input  wire logic             in_valid,
  input  wire logic             req_type,
  input  wire logic [ChW-1:0]   ch,
  input  wire logic             last,
  output logic                  in_ready,
  // Result side.
  input  wire logic             out_free,
  output rhss_res_t             res,
  // Pattern store.
  output logic                  pat_we,
  output logic      [AW-1:0]    pat_waddr,
  output logic      [ChW-1:0]   pat_wdata,
  output logic      [AW-1:0]    pat_raddr,
  input  wire logic [ChW-1:0]   pat_rdata,
  // Window ring.
  output logic                  ring_we,
  output logic      [AW-1:0]    ring_waddr,
  output logic      [ChW-1:0]   ring_wdata,
  output logic      [AW-1:0]    ring_raddr,
  input  wire logic [ChW-1:0]   ring_rdata,
  // Modulo unit.
  output logic      [ModXW-1:0] mod_x,
  input  wire logic [HashW-1:0] mod_r
);

  localparam int LW     = $clog2(MAX_PATTERN + 1);
  localparam int IW     = LW + 1;
  localparam int TW     = $clog2(MAX_TEXT + 1);
  localparam int PW     = ((TW > LW) ? TW : LW) + 1;
  localparam int PosCap = (MAX_TEXT < PosMax) ? MAX_TEXT : PosMax;

  rhss_state_t state, state_next;

  logic [LW-1:0]    len;
  logic [HashW-1:0] pat_hash;
  logic [HashW-1:0] power;
  logic             overflow;
  logic             closed;
  logic [HashW-1:0] win_hash;
  logic [LW-1:0]    fill;
  logic [AW-1:0]    ptr;
  logic [TW-1:0]    tc;
  logic [ChW-1:0]   cur_ch;
  logic             cur_last;
  logic             cur_err;
  logic             res_found;
  logic [PosW-1:0]  res_pos;
  logic [AW-1:0]    walk_k;
  logic [AW-1:0]    walk_idx;

  logic             accept;
  logic             err_now;
  logic [HashW-1:0] hash_eff;
  logic [AW-1:0]    len_eff;
  logic             pat_room;
  logic [AW-1:0]    ptr_inc;
  logic [AW-1:0]    old_idx;
  logic [AW-1:0]    start_idx;
  logic [AW-1:0]    walk_inc;
  logic [HashW:0]   h_sub;
  logic [PW-1:0]    pos_raw;
  logic [PW-1:0]    pos_sat;
  logic             byte_eq;
  logic             walk_end;

  // Ring index that lies l entries behind p.
  function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] p, input logic [LW-1:0] l);
    logic [IW-1:0] pe;
    logic [IW-1:0] le;
    logic [IW-1:0] d;
    pe = IW'(p);
    le = IW'(l);
    if (pe >= le) begin
      d = pe - le;
    end else begin
      d = pe + IW'(MAX_PATTERN) - le;
    end
    return d[AW-1:0];
  endfunction

  // Ring index one ahead, wrapping at the capacity.
  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    if (p == AW'(MAX_PATTERN - 1)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  assign accept   = in_valid && in_ready;
  assign err_now  = (len == '0) || overflow;
  assign hash_eff = closed ? '0 : pat_hash;
  assign len_eff  = closed ? '0 : len[AW-1:0];
  assign pat_room = closed || (len < LW'(MAX_PATTERN));

  assign ptr_inc   = ring_next(ptr);
  assign old_idx   = ring_back(ptr, len);
  assign start_idx = ring_back(ptr_inc, len);
  assign walk_inc  = ring_next(walk_idx);
  assign byte_eq   = (ring_rdata == pat_rdata);
  assign walk_end  = (LW'(walk_k) == len - LW'(1));

  // Remove the leading byte's term from the window hash.
  always_comb begin
    if (win_hash >= mod_r) begin
      h_sub = (HashW + 1)'(win_hash) - (HashW + 1)'(mod_r);
    end else begin
      h_sub = (HashW + 1)'(win_hash) + (HashW + 1)'(HashMod) - (HashW + 1)'(mod_r);
    end
  end

  // 1-based start of the window that ends at the current text byte.
  always_comb begin
    pos_raw = PW'(tc) - PW'(len) + PW'(1);
    if (tc >= TW'(MAX_TEXT)) begin
      pos_sat = PW'(PosCap);
    end else if (pos_raw > PW'(PosCap)) begin
      pos_sat = PW'(PosCap);
    end else begin
      pos_sat = pos_raw;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!req_type) begin
            state_next = pat_room ? ST_PH_Q : ST_IDLE;
          end else if (err_now) begin
            state_next = last ? ST_OUT : ST_IDLE;
          end else if (fill < len) begin
            state_next = ST_ROLL_Q;
          end else begin
            state_next = ST_OLD_RD;
          end
        end
      end
      ST_PH_Q:   state_next = ST_PH_R;
      ST_PH_R:   state_next = (len != '0) ? ST_PP_Q : ST_IDLE;
      ST_PP_Q:   state_next = ST_PP_R;
      ST_PP_R:   state_next = ST_IDLE;
      ST_OLD_RD: state_next = ST_DROP_Q;
      ST_DROP_Q: state_next = ST_DROP_R;
      ST_DROP_R: state_next = ST_ROLL_Q;
      ST_ROLL_Q: state_next = ST_ROLL_R;
      ST_ROLL_R: begin
        if ((fill == len) && (mod_r == pat_hash)) begin
          state_next = ST_V_RD;
        end else begin
          state_next = cur_last ? ST_OUT : ST_IDLE;
        end
      end
      ST_V_RD:   state_next = ST_V_CMP;
      ST_V_CMP: begin
        priority if (!byte_eq) begin
          state_next = cur_last ? ST_OUT : ST_IDLE;
        end else if (walk_end) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_V_RD;
        end
      end
      ST_OUT:    state_next = out_free ? ST_IDLE : ST_OUT;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs: handshake, memory ports and the result beat.
  always_comb begin
    in_ready   = (state == ST_IDLE);
    pat_we     = (state == ST_IDLE) && accept && !req_type && pat_room;
    pat_waddr  = len_eff;
    pat_wdata  = ch;
    pat_raddr  = walk_k;
    ring_we    = (state == ST_ROLL_R);
    ring_waddr = ptr;
    ring_wdata = cur_ch;
    ring_raddr = (state == ST_IDLE) ? old_idx : walk_idx;

    res.load          = (state == ST_OUT) && out_free;
    res.found         = res_found;
    res.position      = res_pos;
    res.done_res      = cur_last;
    res.pattern_error = cur_err;
  end

  // Pattern, window and text bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      pat_hash <= '0;
      power    <= HashW'(1);
      overflow <= 1'b0;
      closed   <= 1'b1;
      win_hash <= '0;
      fill     <= '0;
      ptr      <= '0;
      tc       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && !req_type) begin
            // A pattern byte after a closed pattern starts everything anew.
            if (closed) begin
              len      <= '0;
              pat_hash <= '0;
              power    <= HashW'(1);
              overflow <= 1'b0;
              win_hash <= '0;
              fill     <= '0;
              ptr      <= '0;
              tc       <= '0;
            end else if (!pat_room) begin
              overflow <= 1'b1;
            end
            closed <= last;
          end else if (accept) begin
            closed <= 1'b1;
            if (tc < TW'(MAX_TEXT)) begin
              tc <= tc + TW'(1);
            end
            if (!err_now && (fill < len)) begin
              fill <= fill + LW'(1);
            end
          end
        end
        ST_PH_R: begin
          pat_hash <= mod_r;
          len      <= len + LW'(1);
        end
        ST_PP_R: begin
          power <= mod_r;
        end
        ST_ROLL_R: begin
          win_hash <= mod_r;
          ptr      <= ptr_inc;
        end
        ST_OUT: begin
          // The text state clears once the last byte's result leaves.
          if (out_free && cur_last) begin
            win_hash <= '0;
            fill     <= '0;
            ptr      <= '0;
            tc       <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Operand staging for the modulo unit and the verification walk.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept && !req_type) begin
          mod_x <= ModXW'(hash_eff) * ModXW'(HashBase) + ModXW'(ch);
        end else if (accept) begin
          mod_x     <= ModXW'(win_hash) * ModXW'(HashBase) + ModXW'(ch);
          cur_ch    <= ch;
          cur_last  <= last;
          cur_err   <= err_now;
          res_found <= 1'b0;
          res_pos   <= '0;
        end
      end
      ST_PH_R: begin
        mod_x <= ModXW'(power) * ModXW'(HashBase);
      end
      ST_OLD_RD: begin
        mod_x <= ModXW'(ring_rdata) * ModXW'(power);
      end
      ST_DROP_R: begin
        mod_x <= ModXW'(h_sub) * ModXW'(HashBase) + ModXW'(cur_ch);
      end
      ST_ROLL_R: begin
        walk_k   <= '0;
        walk_idx <= start_idx;
      end
      ST_V_CMP: begin
        walk_k   <= walk_k + AW'(1);
        walk_idx <= walk_inc;
        if (byte_eq && walk_end) begin
          res_found <= 1'b1;
          res_pos   <= PosW'(pos_sat);
        end
      end
      default: begin
      end
    endcase
  end

  // The window never holds more bytes than the pattern.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= len)
    else $error("window fill exceeds pattern length");

  // Hash registers always hold reduced residues.
  a_hash_range: assert property (@(posedge clk) disable iff (rst)
    (win_hash < HashW'(HashMod)) && (pat_hash < HashW'(HashMod)) && (power < HashW'(HashMod)))
    else $error("hash register out of range");

  // Verification runs only on a full window of a valid pattern.
  a_verify_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_V_RD) |-> ((fill == len) && !cur_err))
    else $error("verification walk on a partial window");

  // A result without a match is only the end-of-text beat.
  a_done_only: assert property (@(posedge clk) disable iff (rst)
    (res.load && !res_found) |-> cur_last)
    else $error("empty result beat before the last text byte");

  // A ring write lands one step behind the advanced pointer.
  a_ring_adv: assert property (@(posedge clk) disable iff (rst)
    ring_we |=> (ptr == ring_next($past(ptr))))
    else $error("ring pointer did not advance with its write");

endmodule

`default_nettype wire

/* rtl/core/rolling_hash_substring_search_top.sv */
// Top level of the Rabin-Karp substring search: memories, modulo unit and result register.
`timescale 1ns / 1ps
`default_nettype none

// Pattern bytes (req_type 0) are stored and folded into a base-17 hash modulo 1009; text
// bytes (req_type 1) then roll a window hash and produce a result beat only for a verified
// match or for the last text byte, which carries done_res and pattern_error. A pattern byte
// runs the hash step and, after the first, the power step; one beyond capacity is dropped.
// A text byte rolls the window hash, after dropping the oldest byte's term if the window is
// full; on equal hashes each pattern byte is read and compared. The steps come from the
// shared modulo unit, used at most twice per byte, and from the single registered read port
// of each memory during the walk. A new byte is taken as soon as the sequencer is idle, even
// while an earlier result beat still waits downstream.
module rolling_hash_substring_search_top import rhss_pkg::*; #(
  parameter int MAX_PATTERN = DefMaxPattern,
  parameter int MAX_TEXT    = DefMaxText
) (
  input wire logic clk,
  input wire logic rst,
  rhss_req_if.sink req,
  rhss_res_if.source res
);

  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  rhss_res_t        res_beat;
  logic             out_valid;
  logic             out_free;
  logic             pat_we;
  logic [AW-1:0]    pat_waddr;
  logic [ChW-1:0]   pat_wdata;
  logic [AW-1:0]    pat_raddr;
  logic [ChW-1:0]   pat_rdata;
  logic             ring_we;
  logic [AW-1:0]    ring_waddr;
  logic [ChW-1:0]   ring_wdata;
  logic [AW-1:0]    ring_raddr;
  logic [ChW-1:0]   ring_rdata;
  logic [ModXW-1:0] mod_x;
  logic [HashW-1:0] mod_r;

  assign out_free = !out_valid || res.ready;

  rhss_ctrl #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_TEXT    (MAX_TEXT)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .req_type   (req.req_type),
    .ch         (req.ch),
    .last       (req.last),
    .in_ready   (req.ready),
    .out_free   (out_free),
    .res        (res_beat),
    .pat_we     (pat_we),
    .pat_waddr  (pat_waddr),
    .pat_wdata  (pat_wdata),
    .pat_raddr  (pat_raddr),
    .pat_rdata  (pat_rdata),
    .ring_we    (ring_we),
    .ring_waddr (ring_waddr),
    .ring_wdata (ring_wdata),
    .ring_raddr (ring_raddr),
    .ring_rdata (ring_rdata),
    .mod_x      (mod_x),
    .mod_r      (mod_r)
  );

  rhss_ram #(
    .DEPTH (MAX_PATTERN),
    .WIDTH (ChW)
  ) u_pattern_store (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (pat_wdata),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  rhss_ram #(
    .DEPTH (MAX_PATTERN),
    .WIDTH (ChW)
  ) u_window_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  rhss_mod u_mod (
    .clk (clk),
    .x   (mod_x),
    .r   (mod_r)
  );

  // Output register: holds a result beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_beat.load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_beat.load) begin
      res.found         <= res_beat.found;
      res.position      <= res_beat.position;
      res.done_res      <= res_beat.done_res;
      res.pattern_error <= res_beat.pattern_error;
    end
  end

  assign res.valid = out_valid;

endmodule

`default_nettype wire
